/* src/odr_pkg.sv */
// ----------------------------------------------------------------------------
// odr_pkg
// Types, constants and the quarter-wave sine table for the dead-reckoning
// pose integrator.
// ----------------------------------------------------------------------------
package odr_pkg;

  // Quarter-wave table resolution: 2^SINE_TABLE_BITS steps per quadrant
  localparam int SINE_TABLE_BITS = 10;
  localparam int QUARTER_LEN     = 1 << SINE_TABLE_BITS;
  // Table index width, holds 0..QUARTER_LEN
  localparam int IDX_W           = SINE_TABLE_BITS + 1;
  // Magnitude width of a Q1.15 table entry (entries are 0..32767)
  localparam int MAG_W           = 15;

  // pi in Q2.30 and the Taylor series length used to build the table
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam int     TAYLOR_TERMS = 12;

  typedef logic [MAG_W-1:0] sine_tab_t [QUARTER_LEN+1];

  // Input transaction: one relative odometry step
  typedef struct packed {
    logic              restart;
    logic signed [15:0] step_x;
    logic signed [15:0] step_y;
    logic signed [15:0] step_turn;
  } odr_in_t;

  // Output transaction: global pose after the step
  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] pose_heading;
    logic               clipped;
  } odr_out_t;

  // Shift-subtract quotient for non-negative operands, table build only
  function automatic longint div_pos(longint num, longint den);
    longint quo;
    longint rem;
    quo = 64'sd0;
    rem = 64'sd0;
    for (int b = 63; b >= 0; b--) begin
      rem = (rem << 1) | ((num >> b) & 64'sd1);
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | (64'sd1 << b);
      end
    end
    return quo;
  endfunction

  // Elaboration-time table build: integer Taylor series in Q2.30,
  // every term truncated, then rounded to Q1.15 and capped.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    longint    x;
    longint    term;
    longint    sum;
    longint    v;
    for (int k = 0; k <= QUARTER_LEN; k++) begin
      x    = (longint'(k) * PI_Q30 + longint'(QUARTER_LEN)) >>> (SINE_TABLE_BITS + 1);
      term = x;
      sum  = x;
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
        term = (term * x) >>> 30;
        term = (term * x) >>> 30;
        // terms stay non-negative since the angle is non-negative
        term = div_pos(term, longint'(2 * n) * longint'(2 * n + 1));
        if ((n & 1) != 0) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (sum + 64'sd16384) >>> 15;
      if (v > 64'sd32767) begin
        v = 64'sd32767;
      end
      tab[k] = v[MAG_W-1:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

/* src/odometry_dead_reckoning_integrator_top.sv */
// ----------------------------------------------------------------------------
// odometry_dead_reckoning_integrator_top
// Planar dead reckoning: rotates each odometry step by the current heading,
// adds it to a saturating 32-bit position and advances a wrapping heading.
// ----------------------------------------------------------------------------
// Two register stages: stage 1 and the output register. One transaction per
// cycle while pose is not stalled; the table read for sine and cosine
// happens at acceptance, the rotate and saturating add in the next stage.
// Input stalls only while both stages hold a transaction and pose is stalled.
// Reset (rst, synchronous) clears position, heading and all valid flags; no
// clearing pass is needed.
module odometry_dead_reckoning_integrator_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             step_valid,
  output logic             step_stall,
  input  odr_pkg::odr_in_t step,
  output logic             pose_valid,
  input  logic             pose_stall,
  output odr_pkg::odr_out_t pose
);

  // Front-side heading and stage-1 registers
  logic [15:0]                      heading;
  logic                             s1_valid;
  logic                             s1_restart;
  logic signed [15:0]               s1_x;
  logic signed [15:0]               s1_y;
  logic [15:0]                      s1_heading;
  logic [odr_pkg::MAG_W-1:0]        s1_sin_mag;
  logic [odr_pkg::MAG_W-1:0]        s1_cos_mag;
  logic                             s1_sin_neg;
  logic                             s1_cos_neg;

  // Position state
  logic signed [31:0]               pos_x;
  logic signed [31:0]               pos_y;

  // Handshake
  logic                             accept;
  logic                             advance;

  // Front-side lookup
  logic [15:0]                      h_pre;
  logic [15:0]                      h_post;
  logic [1:0]                       quad;
  logic [odr_pkg::IDX_W-1:0]        frac;
  logic [odr_pkg::IDX_W-1:0]        frac_mirror;
  logic [odr_pkg::IDX_W-1:0]        sin_idx;
  logic [odr_pkg::IDX_W-1:0]        cos_idx;

  // Rotate and accumulate
  logic signed [16:0]               sin_s;
  logic signed [16:0]               cos_s;
  logic signed [32:0]               p_cx;
  logic signed [32:0]               p_sy;
  logic signed [32:0]               p_sx;
  logic signed [32:0]               p_cy;
  logic signed [33:0]               sum_x;
  logic signed [33:0]               sum_y;
  logic signed [18:0]               dx;
  logic signed [18:0]               dy;
  logic signed [31:0]               base_x;
  logic signed [31:0]               base_y;
  logic signed [32:0]               raw_x;
  logic signed [32:0]               raw_y;
  logic                             ovf_x;
  logic                             ovf_y;
  logic signed [31:0]               pos_x_next;
  logic signed [31:0]               pos_y_next;

  // Pipeline control: stage 1 drains when the output register is free
  assign advance    = s1_valid && (!pose_valid || !pose_stall);
  assign step_stall = s1_valid && pose_valid && pose_stall;
  assign accept     = step_valid && !step_stall;

  // Heading before and after this step; table addresses for sin and cos
  assign h_pre       = step.restart ? 16'd0 : heading;
  assign h_post      = h_pre + step.step_turn;
  assign quad        = h_pre[15:14];
  assign frac        = {1'b0, h_pre[13 -: odr_pkg::SINE_TABLE_BITS]};
  assign frac_mirror = odr_pkg::IDX_W'(odr_pkg::QUARTER_LEN) - frac;
  assign sin_idx     = quad[0] ? frac_mirror : frac;
  // cos(a) = sin(a + quarter turn): quadrant advances by one
  assign cos_idx     = quad[0] ? frac : frac_mirror;

  // Front-side heading and stage-1 valid
  always_ff @(posedge clk) begin
    if (rst) begin
      heading  <= '0;
      s1_valid <= 1'b0;
    end else if (accept) begin
      heading  <= h_post;
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage-1 payload with registered table read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_restart <= step.restart;
      s1_x       <= step.step_x;
      s1_y       <= step.step_y;
      s1_heading <= h_post;
      s1_sin_mag <= odr_pkg::SINE_TAB[sin_idx];
      s1_cos_mag <= odr_pkg::SINE_TAB[cos_idx];
      s1_sin_neg <= quad[1];
      s1_cos_neg <= quad[1] ^ quad[0];
    end
  end

  // Signed sine and cosine
  assign sin_s = s1_sin_neg ? -$signed({2'b00, s1_sin_mag}) : $signed({2'b00, s1_sin_mag});
  assign cos_s = s1_cos_neg ? -$signed({2'b00, s1_cos_mag}) : $signed({2'b00, s1_cos_mag});

  // Rotation, one rounding of each sum, floor shift
  assign p_cx  = cos_s * s1_x;
  assign p_sy  = sin_s * s1_y;
  assign p_sx  = sin_s * s1_x;
  assign p_cy  = cos_s * s1_y;
  assign sum_x = 34'(p_cx) - 34'(p_sy) + 34'sd16384;
  assign sum_y = 34'(p_sx) + 34'(p_cy) + 34'sd16384;
  assign dx    = sum_x[33:15];
  assign dy    = sum_y[33:15];

  // Saturating position update
  assign base_x     = s1_restart ? 32'sd0 : pos_x;
  assign base_y     = s1_restart ? 32'sd0 : pos_y;
  assign raw_x      = 33'(base_x) + 33'(dx);
  assign raw_y      = 33'(base_y) + 33'(dy);
  assign ovf_x      = raw_x[32] != raw_x[31];
  assign ovf_y      = raw_y[32] != raw_y[31];
  assign pos_x_next = ovf_x ? (raw_x[32] ? 32'sh80000000 : 32'sh7fffffff) : raw_x[31:0];
  assign pos_y_next = ovf_y ? (raw_y[32] ? 32'sh80000000 : 32'sh7fffffff) : raw_y[31:0];

  // Position state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x      <= '0;
      pos_y      <= '0;
      pose_valid <= 1'b0;
    end else if (advance) begin
      pos_x      <= pos_x_next;
      pos_y      <= pos_y_next;
      pose_valid <= 1'b1;
    end else if (!pose_stall) begin
      pose_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (advance) begin
      pose.pose_x       <= pos_x_next;
      pose.pose_y       <= pos_y_next;
      pose.pose_heading <= s1_heading;
      pose.clipped      <= ovf_x || ovf_y;
    end
  end

endmodule
